/* rtl/core/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared widths, tuple and cell control types, operation and status codes for
// the sorted tuple table.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int DEPTH       = 64;
    localparam int KEY_BITS    = 16;
    localparam int VALUE_BITS  = 32;
    localparam int SOURCE_BITS = 8;
    localparam int IDX_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS    = $clog2(DEPTH + 1);
    localparam int POS_BITS    = 7;
    localparam int ST_BITS     = 2;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [VALUE_BITS-1:0]  value;
        logic [SOURCE_BITS-1:0] source;
    } t_tuple;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctl;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [ST_BITS-1:0] ST_DONE = 2'd0;
    localparam logic [ST_BITS-1:0] ST_MISS = 2'd1;
    localparam logic [ST_BITS-1:0] ST_FULL = 2'd2;

endpackage

/* rtl/core/stt_item_if.sv */
// ----------------------------------------------------------------------------
// stt_item_if
// Request channel: one insert or delete operation per item.
// ----------------------------------------------------------------------------
interface stt_item_if import stt_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [KEY_BITS-1:0]    key_id;
    logic [VALUE_BITS-1:0]  value_id;
    logic [SOURCE_BITS-1:0] source_id;

    modport source (output valid, op, key_id, value_id, source_id, input ready);
    modport sink   (input valid, op, key_id, value_id, source_id, output ready);
endinterface

/* rtl/core/stt_res_if.sv */
// ----------------------------------------------------------------------------
// stt_res_if
// Result channel: status, slot and table occupancy per operation.
// ----------------------------------------------------------------------------
interface stt_res_if import stt_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ST_BITS-1:0]  status;
    logic [POS_BITS-1:0] position;
    logic [POS_BITS-1:0] entry_count;

    modport source (output valid, status, position, entry_count, input ready);
    modport sink   (input valid, status, position, entry_count, output ready);
endinterface

/* rtl/core/sorted_tuple_table.sv */
// ----------------------------------------------------------------------------
// sorted_tuple_table
// Table of (key, value, source) tuples kept sorted by key in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one operation per item: op selects insert or delete of
//   the tuple (key_id, value_id, source_id). o_res returns one item per
//   operation: status (done, duplicate/not found, full), the slot touched
//   and the number of valid tuples afterwards.
//   Every cell compares its tuple with the broadcast item in the compare
//   state; in the update state that follows, the flags are reduced to a
//   slot and the whole row shifts by one place towards or away from that
//   slot. A new item is taken as the previous one leaves its update state,
//   so one item's compare never overlaps another item's update.
//   The result waits in an output register; while the receiver stalls with
//   a result pending, the next item is still accepted and held just before
//   its update until the register frees.
//   Reset empties the table (count zero); slot contents are not cleared and
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_tuple_table import stt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stt_item_if.sink   i_item,
    stt_res_if.source  o_res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic                r_op;
    t_tuple              r_item;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                r_out_valid;
    logic [ST_BITS-1:0]  r_status;
    logic [ST_BITS-1:0]  n_status;
    logic [POS_BITS-1:0] r_position;
    logic [POS_BITS-1:0] n_position;

    t_tuple              cell_tuple [DEPTH];
    logic [DEPTH-1:0]    cell_after;
    logic [DEPTH-1:0]    cell_match;
    logic [DEPTH-1:0]    cell_valid;
    logic [DEPTH-1:0]    del_shift;
    t_cell_ctl           ctl;

    logic                accept;
    logic                advance;
    logic                hit;
    logic                full;
    logic                has_bound;
    logic [IDX_BITS-1:0] match_idx;
    logic [IDX_BITS-1:0] bound_idx;
    logic [CNT_BITS-1:0] ins_pos;

    assign advance        = (r_state == S_UPD) && (!r_out_valid || o_res.ready);
    assign i_item.ready   = (r_state == S_IDLE) || advance;
    assign accept         = i_item.valid && i_item.ready;

    // reduce cell flags to the match slot and the end of the key's run
    always_comb begin
        match_idx = '0;
        bound_idx = '0;
        has_bound = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_match[i]) begin
                match_idx = match_idx | IDX_BITS'(i);
            end
            if (cell_after[i] && ((i == 0) || !cell_after[(i == 0) ? 0 : i - 1])) begin
                bound_idx = bound_idx | IDX_BITS'(i);
                has_bound = 1'b1;
            end
        end
    end

    assign hit     = |cell_match;
    assign full    = (r_count == CNT_BITS'(DEPTH));
    assign ins_pos = has_bound ? CNT_BITS'(bound_idx) : CNT_BITS'(DEPTH);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_valid[i] = CNT_BITS'(i) < r_count;
            del_shift[i]  = IDX_BITS'(i) >= match_idx;
        end
    end

    always_comb begin
        n_count    = r_count;
        n_status   = ST_DONE;
        n_position = POS_BITS'(ins_pos);
        if (r_op == OP_INSERT) begin
            if (hit) begin
                n_status   = ST_MISS;
                n_position = POS_BITS'(match_idx);
            end else if (full) begin
                n_status   = ST_FULL;
            end else begin
                n_count    = r_count + CNT_BITS'(1);
            end
        end else begin
            if (hit) begin
                n_position = POS_BITS'(match_idx);
                n_count    = r_count - CNT_BITS'(1);
            end else begin
                n_status   = ST_MISS;
            end
        end
    end

    assign ctl.cmp = (r_state == S_CMP);
    assign ctl.ins = advance && (r_op == OP_INSERT) && !hit && !full;
    assign ctl.del = advance && (r_op == OP_DELETE) && hit;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        stt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_item       (r_item),
            .i_valid      (cell_valid[g]),
            .i_prev       ((g == 0) ? r_item : cell_tuple[(g == 0) ? 0 : g - 1]),
            .i_prev_after ((g == 0) ? 1'b0 : cell_after[(g == 0) ? 0 : g - 1]),
            .i_next       ((g == DEPTH - 1) ? r_item
                                            : cell_tuple[(g == DEPTH - 1) ? g : g + 1]),
            .i_del_shift  (del_shift[g]),
            .o_tuple      (cell_tuple[g]),
            .o_after      (cell_after[g]),
            .o_match      (cell_match[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (advance) n_state = accept ? S_CMP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op          <= i_item.op;
            r_item.key    <= i_item.key_id;
            r_item.value  <= i_item.value_id;
            r_item.source <= i_item.source_id;
        end
        if (advance) begin
            r_status   <= n_status;
            r_position <= n_position;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.position    = r_position;
    assign o_res.entry_count = POS_BITS'(r_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("entry count beyond table depth");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(cell_match))
        else $error("more than one identical tuple in table");

    a_cmp_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_UPD))
        else $error("compare cycle not followed by update");

    a_update_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("update without result");
`endif

endmodule

/* rtl/core/stt_cell.sv */
// ----------------------------------------------------------------------------
// stt_cell
// One table slot: holds a tuple, compares it against the broadcast item and
// takes its neighbour's tuple or the inserted item when the table shifts.
// ----------------------------------------------------------------------------
module stt_cell import stt_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_tuple    i_item,
    input  logic      i_valid,
    input  t_tuple    i_prev,
    input  logic      i_prev_after,
    input  t_tuple    i_next,
    input  logic      i_del_shift,
    output t_tuple    o_tuple,
    output logic      o_after,
    output logic      o_match
);

    t_tuple r_tuple;
    t_tuple n_tuple;
    logic   r_after;
    logic   r_match;

    always_comb begin
        n_tuple = r_tuple;
        if (i_ctl.ins && r_after) begin
            n_tuple = i_prev_after ? i_prev : i_item;
        end else if (i_ctl.del && i_del_shift) begin
            n_tuple = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tuple <= n_tuple;
        if (i_ctl.cmp) begin
            r_after <= !i_valid || (r_tuple.key > i_item.key);
            r_match <= i_valid && (r_tuple == i_item);
        end
    end

    assign o_tuple = r_tuple;
    assign o_after = r_after;
    assign o_match = r_match;

endmodule
